>>> hw/rtl/efc_pkg.sv
// Shared types and constants for the Ethernet frame classifier.
package efc_pkg;

  // Frame word transfer on the input channel
  typedef struct packed {
    logic [15:0] frame_word;
    logic        last_word;
  } efc_in_t;

  // Classification result on the output channel
  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] peer_port;
    logic [15:0] peer_ip_first;
    logic [15:0] peer_ip_second;
    logic [31:0] echo_replies_seen;
  } efc_out_t;

  // Action codes
  localparam logic [2:0] ACT_DROP        = 3'd0;
  localparam logic [2:0] ACT_ARP_REPLY   = 3'd1;
  localparam logic [2:0] ACT_ECHO_REPLY  = 3'd2;
  localparam logic [2:0] ACT_ECHO_SEEN   = 3'd3;
  localparam logic [2:0] ACT_UDP_DELIVER = 3'd4;
  localparam logic [2:0] ACT_PORT_UNREACH = 3'd5;

  // Configuration register indexes
  localparam logic [1:0] CFG_OWN_IP_FIRST  = 2'd0;
  localparam logic [1:0] CFG_OWN_IP_SECOND = 2'd1;
  localparam logic [1:0] CFG_SERVICE_PORT  = 2'd2;
  localparam logic [1:0] CFG_PEER_KNOWN    = 2'd3;

  // Configuration reset values
  localparam logic [15:0] RST_OWN_IP_FIRST  = 16'd10;
  localparam logic [15:0] RST_OWN_IP_SECOND = 16'd256;
  localparam logic [15:0] RST_SERVICE_PORT  = 16'd502;

  // Frame field codes, as they appear in a word (first wire byte low)
  localparam logic [15:0] ETYPE_IPV4      = 16'h0008;
  localparam logic [15:0] ETYPE_ARP       = 16'h0608;
  localparam logic [15:0] PROTO_ICMP      = 16'h0100;
  localparam logic [15:0] PROTO_UDP       = 16'h1100;
  localparam logic [15:0] PROTO_MASK      = 16'hFF00;
  localparam logic [15:0] ICMP_ECHO_REPLY = 16'h0000;
  localparam logic [15:0] ICMP_ECHO_REQ   = 16'h0008;
  localparam logic [15:0] ARP_OP_REQUEST  = 16'h0100;

  // Word positions within the frame
  localparam int unsigned CAP_COUNT = 15;
  localparam logic [4:0] POS_CAP_FIRST = 5'd6;
  localparam logic [4:0] POS_CAP_LAST  = 5'd20;
  localparam logic [4:0] POS_SUM_FIRST = 5'd7;
  localparam logic [4:0] POS_SUM_LAST  = 5'd16;
  localparam logic [4:0] POS_CSUM      = 5'd12;
  localparam logic [4:0] POS_MAX       = 5'd31;

  // Slots of the capture array (frame word minus six)
  localparam int unsigned SLOT_ETYPE    = 0;
  localparam int unsigned SLOT_ARP_OP   = 4;
  localparam int unsigned SLOT_PROTO    = 5;
  localparam int unsigned SLOT_CSUM     = 6;
  localparam int unsigned SLOT_SRC_IP0  = 7;
  localparam int unsigned SLOT_SRC_IP1  = 8;
  localparam int unsigned SLOT_DST_IP0  = 9;
  localparam int unsigned SLOT_DST_IP1  = 10;
  localparam int unsigned SLOT_L4_W0    = 11;
  localparam int unsigned SLOT_L4_W1    = 12;
  localparam int unsigned SLOT_ARP_TIP0 = 13;
  localparam int unsigned SLOT_ARP_TIP1 = 14;

endpackage

>>> hw/rtl/eth_frame_classifier.sv
// Ethernet receive frame classifier: header capture, IPv4 checksum, action decode.
//
// Usage:
//   in_*  : one 16-bit frame word per transfer, first wire byte in bits 7:0,
//           last_word marks the final word of a frame.
//   out_* : one result per frame, given for the transfer that carries last_word:
//           action, peer UDP port, peer IPv4 address words, echo reply count.
//   cfg_* : register writes (index, data), always ready; write only while idle.
// Path: a word is registered in the input stage and its result, if any, is
//   loaded into the output register when that final word leaves the input stage.
// Throughput: one word per cycle. Non-final words only update the position,
//   header sum and capture registers and never wait for the output side.
// Stall: while a result sits unread in the output register, a final word is
//   held in the input stage; in_ready drops only when that stage is occupied
//   and cannot advance.
// Reset: synchronous, active low; clears the position, header sum, echo
//   counter, valid flags and loads the configuration defaults.
module eth_frame_classifier
  import efc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // frame word input
  input  logic        in_valid,
  output logic        in_ready,
  input  efc_in_t     in_data,
  // classification output
  output logic        out_valid,
  input  logic        out_ready,
  output efc_out_t    out_data,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // configuration registers
  logic [15:0] own_ip0_r;
  logic [15:0] own_ip1_r;
  logic [15:0] svc_port_r;
  logic        peer_known_r;

  // input stage
  logic        s0_valid_r;
  efc_in_t     s0_data_r;
  logic        s0_adv;

  // frame state
  logic [4:0]  pos_r;
  logic [4:0]  pos_nxt;
  logic [19:0] sum_r;
  logic [19:0] sum_nxt;
  logic [15:0] cap_r [CAP_COUNT];
  logic [31:0] echo_cnt_r;
  logic [31:0] echo_cnt_nxt;

  // output stage
  logic        out_valid_r;
  efc_out_t    out_data_r;
  efc_out_t    res_nxt;
  logic        out_free;

  // classification terms
  logic        in_cap_range;
  logic        in_sum_range;
  logic [3:0]  cap_slot;
  logic [15:0] arp_tip1;
  logic [16:0] fold1;
  logic [16:0] fold2;
  logic [15:0] csum;
  logic [15:0] proto;
  logic        ip_match;
  logic        long_enough;

  // handshakes
  assign out_free  = !out_valid_r || out_ready;
  assign s0_adv    = s0_valid_r && (!s0_data_r.last_word || out_free);
  assign in_ready  = !s0_valid_r || s0_adv;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_ip0_r    <= RST_OWN_IP_FIRST;
      own_ip1_r    <= RST_OWN_IP_SECOND;
      svc_port_r   <= RST_SERVICE_PORT;
      peer_known_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_OWN_IP_FIRST:  own_ip0_r    <= cfg_data;
        CFG_OWN_IP_SECOND: own_ip1_r    <= cfg_data;
        CFG_SERVICE_PORT:  svc_port_r   <= cfg_data;
        CFG_PEER_KNOWN:    peer_known_r <= cfg_data[0];
        default:           peer_known_r <= peer_known_r;
      endcase
    end
  end

  // input stage: load on transfer, empty when the word advances
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_ready) begin
      s0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s0_data_r <= in_data;
    end
  end

  // position and header sum window
  assign in_cap_range = (pos_r >= POS_CAP_FIRST) && (pos_r <= POS_CAP_LAST);
  assign in_sum_range = (pos_r >= POS_SUM_FIRST) && (pos_r <= POS_SUM_LAST) &&
                        (pos_r != POS_CSUM);
  assign cap_slot     = 4'(pos_r - POS_CAP_FIRST);

  always_comb begin
    pos_nxt = pos_r;
    sum_nxt = sum_r;
    if (s0_data_r.last_word) begin
      pos_nxt = '0;
      sum_nxt = '0;
    end else begin
      if (pos_r != POS_MAX) pos_nxt = pos_r + 5'd1;
      if (in_sum_range) sum_nxt = sum_r + {4'd0, s0_data_r.frame_word};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      sum_r <= '0;
    end else if (s0_adv) begin
      pos_r <= pos_nxt;
      sum_r <= sum_nxt;
    end
  end

  // capture header words; written before any read of the same frame
  always_ff @(posedge clk) begin
    if (s0_adv && in_cap_range) begin
      cap_r[cap_slot] <= s0_data_r.frame_word;
    end
  end

  // fold the header sum twice and complement
  assign fold1 = {1'b0, sum_r[15:0]} + {13'd0, sum_r[19:16]};
  assign fold2 = {1'b0, fold1[15:0]} + {16'd0, fold1[16]};
  assign csum  = ~fold2[15:0];

  // the final ARP word may be the word in the input stage
  assign arp_tip1    = (pos_r == POS_CAP_LAST) ? s0_data_r.frame_word
                                               : cap_r[SLOT_ARP_TIP1];
  assign long_enough = (pos_r >= POS_CAP_LAST);
  assign proto       = cap_r[SLOT_PROTO] & PROTO_MASK;
  assign ip_match    = peer_known_r && (cap_r[SLOT_DST_IP0] == own_ip0_r) &&
                       (cap_r[SLOT_DST_IP1] == own_ip1_r) &&
                       (csum == cap_r[SLOT_CSUM]);

  // classify the frame on its final word
  always_comb begin
    res_nxt      = '0;
    echo_cnt_nxt = echo_cnt_r;
    if (long_enough) begin
      priority if (cap_r[SLOT_ETYPE] == ETYPE_IPV4) begin
        res_nxt.peer_ip_first  = cap_r[SLOT_SRC_IP0];
        res_nxt.peer_ip_second = cap_r[SLOT_SRC_IP1];
        if (ip_match) begin
          priority if (proto == PROTO_ICMP) begin
            priority if (cap_r[SLOT_L4_W0] == ICMP_ECHO_REPLY) begin
              echo_cnt_nxt   = echo_cnt_r + 32'd1;
              res_nxt.action = ACT_ECHO_SEEN;
            end else if (cap_r[SLOT_L4_W0] == ICMP_ECHO_REQ) begin
              res_nxt.action = ACT_ECHO_REPLY;
            end else begin
              res_nxt.action = ACT_DROP;
            end
          end else if (proto == PROTO_UDP) begin
            res_nxt.peer_port = {cap_r[SLOT_L4_W0][7:0], cap_r[SLOT_L4_W0][15:8]};
            res_nxt.action    =
              ({cap_r[SLOT_L4_W1][7:0], cap_r[SLOT_L4_W1][15:8]} == svc_port_r)
              ? ACT_UDP_DELIVER : ACT_PORT_UNREACH;
          end else begin
            res_nxt.action = ACT_DROP;
          end
        end
      end else if (cap_r[SLOT_ETYPE] == ETYPE_ARP) begin
        if ((cap_r[SLOT_ARP_OP] == ARP_OP_REQUEST) &&
            (cap_r[SLOT_ARP_TIP0] == own_ip0_r) && (arp_tip1 == own_ip1_r)) begin
          res_nxt.action = ACT_ARP_REPLY;
        end
      end else begin
        res_nxt.action = ACT_DROP;
      end
    end
    res_nxt.echo_replies_seen = echo_cnt_nxt;
  end

  // echo reply counter advances with the final word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      echo_cnt_r <= '0;
    end else if (s0_adv && s0_data_r.last_word) begin
      echo_cnt_r <= echo_cnt_nxt;
    end
  end

  // output register: drop on transfer, load on a final word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s0_adv && s0_data_r.last_word) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_adv && s0_data_r.last_word) begin
      out_data_r <= res_nxt;
    end
  end

`ifndef SYNTH
  // a new result only follows a final word leaving the input stage
  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s0_adv && s0_data_r.last_word))
    else $error("result without a final word");

  // peer port only carries meaning for UDP actions
  a_port_only_udp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.peer_port != 16'd0)) |->
      (out_data_r.action == ACT_UDP_DELIVER || out_data_r.action == ACT_PORT_UNREACH))
    else $error("peer port set for non-UDP action");

  // counter moves only together with an echo-reply-seen result
  a_count_with_echo: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (echo_cnt_r != $past(echo_cnt_r))) |->
      (out_valid_r && out_data_r.action == ACT_ECHO_SEEN &&
       out_data_r.echo_replies_seen == echo_cnt_r))
    else $error("echo counter moved without an echo reply result");

  // action codes stay within the defined set
  a_action_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.action <= ACT_PORT_UNREACH))
    else $error("undefined action code");
`endif

endmodule

>>> dv/eth_frame_classifier_checker.sv
// Monitor, frame classification predictor and result comparison for the frame classifier.
module eth_frame_classifier_checker
  import efc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  efc_in_t     in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  efc_out_t    out_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          mismatches,
  output int          results_due
);
  timeunit 1ns;
  timeprecision 1ps;

  // Register copies, updated from observed cfg transfers
  logic [15:0] own_ip0;
  logic [15:0] own_ip1;
  logic [15:0] svc_port;
  logic        peer_ok;

  // Frame tracking state
  logic [4:0]  word_pos;
  logic [19:0] hdr_sum;
  logic [15:0] hdr_words [CAP_COUNT];
  logic [31:0] echo_seen;

  // Classifications waiting for their output transfer, oldest first
  efc_out_t due_results [$];

  // Print one line and count a mismatch
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("%0t: %s got %h expected %h", $time, what, got, want);
  endtask

  function automatic logic [15:0] swap_bytes(input logic [15:0] v);
    return {v[7:0], v[15:8]};
  endfunction

  // Track one frame word; on the last word, classify the frame and queue the result
  task automatic absorb_word(input efc_in_t it);
    logic [4:0]  pos;
    logic [16:0] folded;
    logic [15:0] csum;
    logic [15:0] proto;
    efc_out_t    res;
    pos = word_pos;
    if (pos >= POS_CAP_FIRST && pos <= POS_CAP_LAST)
      hdr_words[4'(pos - POS_CAP_FIRST)] = it.frame_word;
    if (pos >= POS_SUM_FIRST && pos <= POS_SUM_LAST && pos != POS_CSUM)
      hdr_sum = hdr_sum + {4'd0, it.frame_word};
    if (!it.last_word) begin
      if (pos != POS_MAX)
        word_pos = pos + 5'd1;
      return;
    end
    res = '0;
    res.action = ACT_DROP;
    // Short frames never reach the classification below
    if (pos >= POS_CAP_LAST) begin
      if (hdr_words[SLOT_ETYPE] == ETYPE_IPV4) begin
        // Fold twice so that a carry out of the first fold is absorbed
        folded = {1'b0, hdr_sum[15:0]} + {13'd0, hdr_sum[19:16]};
        folded = {1'b0, folded[15:0]} + {16'd0, folded[16]};
        csum = ~folded[15:0];
        res.peer_ip_first  = hdr_words[SLOT_SRC_IP0];
        res.peer_ip_second = hdr_words[SLOT_SRC_IP1];
        if (peer_ok && hdr_words[SLOT_DST_IP0] == own_ip0 &&
            hdr_words[SLOT_DST_IP1] == own_ip1 && csum == hdr_words[SLOT_CSUM]) begin
          proto = hdr_words[SLOT_PROTO] & PROTO_MASK;
          if (proto == PROTO_ICMP) begin
            if (hdr_words[SLOT_L4_W0] == ICMP_ECHO_REPLY) begin
              echo_seen++;
              res.action = ACT_ECHO_SEEN;
            end else if (hdr_words[SLOT_L4_W0] == ICMP_ECHO_REQ) begin
              res.action = ACT_ECHO_REPLY;
            end
          end else if (proto == PROTO_UDP) begin
            res.peer_port = swap_bytes(hdr_words[SLOT_L4_W0]);
            res.action = (swap_bytes(hdr_words[SLOT_L4_W1]) == svc_port) ?
                         ACT_UDP_DELIVER : ACT_PORT_UNREACH;
          end
        end
      end else if (hdr_words[SLOT_ETYPE] == ETYPE_ARP) begin
        if (hdr_words[SLOT_ARP_OP] == ARP_OP_REQUEST &&
            hdr_words[SLOT_ARP_TIP0] == own_ip0 && hdr_words[SLOT_ARP_TIP1] == own_ip1)
          res.action = ACT_ARP_REPLY;
      end
    end
    res.echo_replies_seen = echo_seen;
    due_results.push_back(res);
    word_pos = '0;
    hdr_sum = '0;
  endtask

  // Compare one output transfer against the oldest queued classification
  task automatic check_result(input efc_out_t got);
    efc_out_t want;
    if (due_results.size() == 0) begin
      report_mismatch("result with nothing due, action", 32'(got.action), '0);
      return;
    end
    want = due_results.pop_front();
    if (got.action !== want.action)
      report_mismatch("action", 32'(got.action), 32'(want.action));
    if (got.peer_port !== want.peer_port)
      report_mismatch("peer_port", 32'(got.peer_port), 32'(want.peer_port));
    if (got.peer_ip_first !== want.peer_ip_first)
      report_mismatch("peer_ip_first", 32'(got.peer_ip_first), 32'(want.peer_ip_first));
    if (got.peer_ip_second !== want.peer_ip_second)
      report_mismatch("peer_ip_second", 32'(got.peer_ip_second),
                      32'(want.peer_ip_second));
    if (got.echo_replies_seen !== want.echo_replies_seen)
      report_mismatch("echo_replies_seen", got.echo_replies_seen, want.echo_replies_seen);
  endtask

  // Watch all three channels at each rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      own_ip0 = RST_OWN_IP_FIRST;
      own_ip1 = RST_OWN_IP_SECOND;
      svc_port = RST_SERVICE_PORT;
      peer_ok = 1'b0;
      word_pos = '0;
      hdr_sum = '0;
      echo_seen = '0;
      due_results.delete();
    end else begin
      if (out_valid && out_ready)
        check_result(out_data);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_OWN_IP_FIRST:  own_ip0 = cfg_data;
          CFG_OWN_IP_SECOND: own_ip1 = cfg_data;
          CFG_SERVICE_PORT:  svc_port = cfg_data;
          CFG_PEER_KNOWN:    peer_ok = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        absorb_word(in_data);
    end
    results_due = due_results.size();
  end

endmodule

>>> dv/eth_frame_classifier_tb.sv
// Top of the frame classifier testbench: clock, reset, frame stimulus and verdict.
module eth_frame_classifier_tb;
  import efc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_WORDS = 800;
  localparam int RANDOM_PHASES = 6;
  localparam int IDLE_LIMIT = 1000;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES = 8;
  localparam int MAX_IDLE = 11;

  // Word positions within a frame
  localparam int FULL_WORDS    = POS_CAP_LAST + 1;
  localparam int WORD_ETYPE    = POS_CAP_FIRST + SLOT_ETYPE;
  localparam int WORD_IP_ID    = POS_CAP_FIRST + 3;
  localparam int WORD_ARP_OP   = POS_CAP_FIRST + SLOT_ARP_OP;
  localparam int WORD_PROTO    = POS_CAP_FIRST + SLOT_PROTO;
  localparam int WORD_CSUM     = POS_CAP_FIRST + SLOT_CSUM;
  localparam int WORD_DST_IP0  = POS_CAP_FIRST + SLOT_DST_IP0;
  localparam int WORD_L4_W0    = POS_CAP_FIRST + SLOT_L4_W0;
  localparam int WORD_L4_W1    = POS_CAP_FIRST + SLOT_L4_W1;
  localparam int WORD_ARP_TIP0 = POS_CAP_FIRST + SLOT_ARP_TIP0;

  // IPv4 kinds first, then ARP kinds, then a foreign ethertype
  typedef enum int {
    FRAME_ECHO_REQ,
    FRAME_ECHO_REPLY,
    FRAME_ICMP_OTHER,
    FRAME_UDP_SERVICE,
    FRAME_UDP_OTHER,
    FRAME_IP_OTHER,
    FRAME_ARP_OURS,
    FRAME_ARP_FOREIGN,
    FRAME_ARP_OTHER_OP,
    FRAME_ETYPE_OTHER
  } frame_kind_e;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  efc_in_t     in_data;
  logic        out_valid;
  logic        out_ready;
  efc_out_t    out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  int          mismatches;
  int          results_due;

  // Register values in force, used to shape well-formed frames
  logic [15:0] own_ip0;
  logic [15:0] own_ip1;
  logic [15:0] svc_port;

  logic [15:0] frame_q [$];
  int          words_sent;
  bit          sender_calm;
  bit          receiver_calm;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  eth_frame_classifier u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  eth_frame_classifier_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .results_due (results_due)
  );

  // Fill frame_q with one frame of the given kind and length
  function automatic void build_frame(input frame_kind_e kind, input int n_words,
                                      input bit bad_csum, input bit foreign,
                                      input bit carry);
    logic [15:0] fw [FULL_WORDS];
    logic [19:0] sum;
    logic [16:0] folded;
    int          flip;
    for (int i = 0; i < FULL_WORDS; i++)
      fw[i] = 16'($urandom);
    flip = $urandom_range(0, 15);
    if (kind <= FRAME_IP_OTHER) begin
      fw[WORD_ETYPE] = ETYPE_IPV4;
      fw[WORD_DST_IP0] = own_ip0;
      fw[WORD_DST_IP0 + 1] = own_ip1;
      if (foreign)
        fw[WORD_DST_IP0 + $urandom_range(0, 1)] ^= 16'(1) << flip;
      case (kind)
        FRAME_ECHO_REQ: begin
          fw[WORD_PROTO][15:8] = PROTO_ICMP[15:8];
          fw[WORD_L4_W0] = ICMP_ECHO_REQ;
        end
        FRAME_ECHO_REPLY: begin
          fw[WORD_PROTO][15:8] = PROTO_ICMP[15:8];
          fw[WORD_L4_W0] = ICMP_ECHO_REPLY;
        end
        FRAME_ICMP_OTHER: begin
          // bit 8 set keeps the type/code word away from both echo codes
          fw[WORD_PROTO][15:8] = PROTO_ICMP[15:8];
          fw[WORD_L4_W0] |= 16'h0100;
        end
        FRAME_UDP_SERVICE: begin
          fw[WORD_PROTO][15:8] = PROTO_UDP[15:8];
          fw[WORD_L4_W1] = {svc_port[7:0], svc_port[15:8]};
        end
        FRAME_UDP_OTHER:
          fw[WORD_PROTO][15:8] = PROTO_UDP[15:8];
        FRAME_IP_OTHER: begin
          if (fw[WORD_PROTO][15:8] == PROTO_ICMP[15:8] ||
              fw[WORD_PROTO][15:8] == PROTO_UDP[15:8])
            fw[WORD_PROTO][15] = ~fw[WORD_PROTO][15];
        end
        default: ;
      endcase
      // Pick the identification word so the header sum ends in all ones,
      // which forces a carry out of the first fold unless the upper sum bits are zero
      sum = '0;
      if (carry) begin
        for (int i = POS_SUM_FIRST; i <= POS_SUM_LAST; i++)
          if (i != POS_CSUM && i != WORD_IP_ID)
            sum += {4'd0, fw[i]};
        fw[WORD_IP_ID] = ~sum[15:0];
        sum = '0;
      end
      for (int i = POS_SUM_FIRST; i <= POS_SUM_LAST; i++)
        if (i != POS_CSUM)
          sum += {4'd0, fw[i]};
      folded = {1'b0, sum[15:0]} + {13'd0, sum[19:16]};
      folded = {1'b0, folded[15:0]} + {16'd0, folded[16]};
      fw[WORD_CSUM] = ~folded[15:0];
      if (bad_csum)
        fw[WORD_CSUM] ^= 16'(1) << flip;
    end else if (kind != FRAME_ETYPE_OTHER) begin
      fw[WORD_ETYPE] = ETYPE_ARP;
      fw[WORD_ARP_OP] = ARP_OP_REQUEST;
      fw[WORD_ARP_TIP0] = own_ip0;
      fw[WORD_ARP_TIP0 + 1] = own_ip1;
      if (kind == FRAME_ARP_OTHER_OP)
        fw[WORD_ARP_OP] ^= 16'(1) << flip;
      if (kind == FRAME_ARP_FOREIGN)
        fw[WORD_ARP_TIP0 + $urandom_range(0, 1)] ^= 16'(1) << flip;
    end else if (fw[WORD_ETYPE] == ETYPE_IPV4 || fw[WORD_ETYPE] == ETYPE_ARP) begin
      fw[WORD_ETYPE][15] = 1'b1;
    end
    frame_q.delete();
    for (int i = 0; i < n_words; i++)
      frame_q.push_back(i < FULL_WORDS ? fw[i] : 16'($urandom));
  endfunction

  // Drive one word and hold it until the transfer
  task automatic send_word(input logic [15:0] w, input bit last);
    int gap;
    gap = sender_calm ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{frame_word: w, last_word: last};
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  task automatic send_frame(input frame_kind_e kind, input int n_words, input bit bad_csum,
                            input bit foreign, input bit carry);
    build_frame(kind, n_words, bad_csum, foreign, carry);
    foreach (frame_q[i])
      send_word(frame_q[i], i == frame_q.size() - 1);
  endtask

  // Stop sending and wait until every queued classification has come out
  task automatic wait_results(input int extra);
    in_valid <= 1'b0;
    do @(negedge clk); while (results_due != 0);
    repeat (extra) @(posedge clk);
  endtask

  task automatic put_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Write all four registers back to back; only call while idle
  task automatic configure(input logic [15:0] ip0, input logic [15:0] ip1,
                           input logic [15:0] port, input bit known);
    put_reg(CFG_OWN_IP_FIRST, ip0);
    put_reg(CFG_OWN_IP_SECOND, ip1);
    put_reg(CFG_SERVICE_PORT, port);
    put_reg(CFG_PEER_KNOWN, {15'd0, known});
    cfg_valid <= 1'b0;
    own_ip0 = ip0;
    own_ip1 = ip1;
    svc_port = port;
  endtask

  // Random frames under one register setting until the word goal is reached
  task automatic run_phase(input logic [15:0] ip0, input logic [15:0] ip1,
                           input logic [15:0] port, input bit known, input int word_goal);
    int pick;
    int n_words;
    wait_results(SETTLE_CYCLES);
    configure(ip0, ip1, port, known);
    while (words_sent < word_goal) begin
      sender_calm = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 99);
      n_words = (pick < 10) ? $urandom_range(1, FULL_WORDS - 1) :
                (pick < 85) ? $urandom_range(FULL_WORDS, FULL_WORDS + 2) :
                              $urandom_range(FULL_WORDS + 3, 40);
      send_frame(frame_kind_e'($urandom_range(0, FRAME_ETYPE_OTHER)), n_words,
                 $urandom_range(0, 11) == 0, $urandom_range(0, 11) == 0,
                 $urandom_range(0, 5) == 0);
      if ($urandom_range(0, 24) == 0)
        wait_results(1);
    end
  endtask

  // Result side: stall a random number of cycles before each transfer
  initial begin : result_sink
    int stall;
    out_ready <= 1'b0;
    receiver_calm = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = receiver_calm ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if ($urandom_range(0, 9) == 0)
        receiver_calm = !receiver_calm;
    end
  end

  // End the run when no channel has moved for too long
  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready))
        stuck = 0;
      else
        stuck++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    int base;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_OWN_IP_FIRST;
    cfg_data <= '0;
    own_ip0 = RST_OWN_IP_FIRST;
    own_ip1 = RST_OWN_IP_SECOND;
    svc_port = RST_SERVICE_PORT;
    words_sent = 0;
    sender_calm = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings, peer unknown: short frames, ARP still answered, IP dropped
    send_frame(FRAME_ECHO_REQ, 1, 1'b0, 1'b0, 1'b0);
    send_frame(FRAME_ARP_OURS, FULL_WORDS - 1, 1'b0, 1'b0, 1'b0);
    send_frame(FRAME_ARP_OURS, FULL_WORDS, 1'b0, 1'b0, 1'b0);
    send_frame(FRAME_ECHO_REQ, FULL_WORDS, 1'b0, 1'b0, 1'b0);
    wait_results(SETTLE_CYCLES);

    // Peer known: every kind once, then the corner cases
    configure(16'hA8C0, 16'h0201, 16'h3930, 1'b1);
    for (int k = 0; k <= FRAME_ETYPE_OTHER; k++)
      send_frame(frame_kind_e'(k), FULL_WORDS, 1'b0, 1'b0, 1'b0);
    send_frame(FRAME_ECHO_REPLY, FULL_WORDS, 1'b0, 1'b0, 1'b0);
    send_frame(FRAME_UDP_SERVICE, FULL_WORDS, 1'b1, 1'b0, 1'b0);
    send_frame(FRAME_ECHO_REQ, FULL_WORDS, 1'b0, 1'b1, 1'b0);
    send_frame(FRAME_UDP_SERVICE, 40, 1'b0, 1'b0, 1'b1);
    send_frame(FRAME_ECHO_REPLY, FULL_WORDS + 12, 1'b0, 1'b0, 1'b1);
    wait_results(1);

    // Random part: extremes first, then a peer-unknown phase, then random settings
    base = words_sent;
    run_phase(16'h0000, 16'h0000, 16'h0000, 1'b1, base + RANDOM_WORDS / RANDOM_PHASES);
    run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, base + 2 * RANDOM_WORDS / RANDOM_PHASES);
    run_phase(16'($urandom), 16'($urandom), 16'($urandom), 1'b0,
              base + 3 * RANDOM_WORDS / RANDOM_PHASES);
    for (int p = 4; p <= RANDOM_PHASES; p++)
      run_phase(16'($urandom), 16'($urandom), 16'($urandom), 1'b1,
                base + p * RANDOM_WORDS / RANDOM_PHASES);

    // Drain, give late or extra results time to show up, then decide
    wait_results(TAIL_CYCLES);
    @(negedge clk);
    if (mismatches == 0 && results_due == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
